### rtl/core/amsc_pkg.sv
// shared types, widths and constants of the magnitude step counter
`default_nettype none

package amsc_pkg;

  localparam int AXIS_W      = 16;
  localparam int SQ_W        = 2 * AXIS_W;
  localparam int MAG_W       = SQ_W / 2;
  localparam int REM_W       = MAG_W + 2;
  localparam int CNT_W       = $clog2(AXIS_W);
  localparam int THR_W       = 16;
  localparam int GAP_W       = 8;
  localparam int STEP_W      = 16;
  localparam int FRAME_W     = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000);
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(4);
  localparam logic [GAP_W-1:0] GAP_TOP   = 8'hff;

  localparam int FRAME_SAMPLES_DEF = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PEAK_GAP   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_FINISH
  } state_t;

  // control of a serial unit: load operands, then one step per cycle
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

endpackage

`default_nettype wire

### rtl/core/amsc_square.sv
// bit-serial shift-add squarer for one axis magnitude
`default_nettype none

module amsc_square (
  input  wire                              clk,
  input  wire  amsc_pkg::ser_ctl_t         ctl,
  input  wire  [amsc_pkg::AXIS_W-1:0]      operand,
  output logic [amsc_pkg::SQ_W-1:0]        product
);

  logic [amsc_pkg::AXIS_W-1:0] mcand_r;
  logic [amsc_pkg::AXIS_W-1:0] hi_r;
  logic [amsc_pkg::AXIS_W-1:0] lo_r;
  logic [amsc_pkg::AXIS_W:0]   sum;

  // add the multiplicand into the high half when the current multiplier bit is set
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand_r <= operand;
      hi_r    <= '0;
      lo_r    <= operand;
    end else if (ctl.step) begin
      hi_r <= sum[amsc_pkg::AXIS_W:1];
      lo_r <= {sum[0], lo_r[amsc_pkg::AXIS_W-1:1]};
    end
  end

  assign product = {hi_r, lo_r};

endmodule

`default_nettype wire

### rtl/core/amsc_isqrt.sv
// restoring integer square root, one result bit per step
`default_nettype none

module amsc_isqrt (
  input  wire                              clk,
  input  wire  amsc_pkg::ser_ctl_t         ctl,
  input  wire  [amsc_pkg::SQ_W-1:0]        radicand,
  output logic [amsc_pkg::MAG_W-1:0]       root
);

  logic [amsc_pkg::SQ_W-1:0]  rad_r;
  logic [amsc_pkg::REM_W-1:0] rem_r;
  logic [amsc_pkg::MAG_W-1:0] root_r;
  logic [amsc_pkg::REM_W:0]   rem_sh;
  logic [amsc_pkg::REM_W:0]   trial;
  logic                       fits;

  // bring down the next two radicand bits, try 4*root+1
  assign rem_sh = {rem_r[amsc_pkg::REM_W-2:0], rad_r[amsc_pkg::SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctl.step) begin
      rad_r  <= {rad_r[amsc_pkg::SQ_W-3:0], 2'b00};
      rem_r  <= fits ? amsc_pkg::REM_W'(rem_sh - trial) : amsc_pkg::REM_W'(rem_sh);
      root_r <= {root_r[amsc_pkg::MAG_W-2:0], fits};
    end
  end

  assign root = root_r;

endmodule

`default_nettype wire

### rtl/core/accel_magnitude_step_counter_core.sv
// top level: sequencer, peak tracking and result register of the step counter
// sequence: an accepted sample runs 16 squaring steps, a sum state, 16 root steps and an
//   update; report requests and dropped samples go straight to the update
// throughput: one transaction at a time, next accepted the cycle after the update,
//   and the update waits while a result is held with out_ready low
// reset: rst_n synchronous active low, clears peak state, counts and out_valid, sets config defaults
`default_nettype none

module accel_magnitude_step_counter_core #(
  parameter int FRAME_SAMPLES = amsc_pkg::FRAME_SAMPLES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,

  // configuration writes
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [amsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [amsc_pkg::CFG_DATA_W-1:0]      cfg_data,

  // sample transactions
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_mode,
  input  wire  signed [amsc_pkg::AXIS_W-1:0]   in_accel_x,
  input  wire  signed [amsc_pkg::AXIS_W-1:0]   in_accel_y,
  input  wire  signed [amsc_pkg::AXIS_W-1:0]   in_accel_z,

  // result transactions
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [amsc_pkg::STEP_W-1:0]          out_step_count,
  output logic                                 out_step_taken,
  output logic                                 out_sample_used,
  output logic [amsc_pkg::MAG_W-1:0]           out_magnitude
);

  localparam logic [amsc_pkg::CNT_W-1:0]   CNT_LAST  = amsc_pkg::CNT_W'(amsc_pkg::AXIS_W - 1);
  localparam logic [amsc_pkg::FRAME_W-1:0] FRAME_END = amsc_pkg::FRAME_W'(FRAME_SAMPLES);

  // configuration registers
  logic [amsc_pkg::THR_W-1:0]   jump_thr_r;
  logic [amsc_pkg::GAP_W-1:0]   max_gap_r;

  // tracking state
  logic [amsc_pkg::MAG_W-1:0]   prev_mag_r, prev_mag_nxt;
  logic                         high_r, high_nxt;
  logic                         low_r, low_nxt;
  logic [amsc_pkg::GAP_W-1:0]   gap_r, gap_nxt;
  logic [amsc_pkg::STEP_W-1:0]  steps_r, steps_nxt;
  logic [amsc_pkg::FRAME_W-1:0] frame_r, frame_nxt;

  // sequencer
  amsc_pkg::state_t             state_r, state_nxt;
  logic [amsc_pkg::CNT_W-1:0]   cnt_r;
  logic                         mode_r;
  logic                         drop_r;
  logic                         frame_full;
  logic                         out_free;
  logic                         finish_en;
  amsc_pkg::ser_ctl_t           sq_ctl;
  amsc_pkg::ser_ctl_t           rt_ctl;

  // result register
  logic                         out_valid_r;
  logic [amsc_pkg::STEP_W-1:0]  out_count_r;
  logic                         out_taken_r;
  logic                         out_used_r;
  logic [amsc_pkg::MAG_W-1:0]   out_mag_r;

  // datapath
  logic [amsc_pkg::AXIS_W-1:0]  abs_x, abs_y, abs_z;
  logic [amsc_pkg::SQ_W-1:0]    sq_x, sq_y, sq_z;
  logic [amsc_pkg::SQ_W-1:0]    sum_sq;
  logic [amsc_pkg::MAG_W-1:0]   mag;
  logic                         stepped;
  logic signed [amsc_pkg::MAG_W+1:0] diff;
  logic signed [amsc_pkg::MAG_W+1:0] thr_s;

  // no writes are taken while reset is held
  assign cfg_ready  = rst_n;
  assign frame_full = (frame_r >= FRAME_END);
  assign out_free   = !out_valid_r || out_ready;

  // absolute values, most negative code maps to 2^15 which still fits unsigned
  assign abs_x = in_accel_x[amsc_pkg::AXIS_W-1] ? (~in_accel_x + 1'b1) : in_accel_x;
  assign abs_y = in_accel_y[amsc_pkg::AXIS_W-1] ? (~in_accel_y + 1'b1) : in_accel_y;
  assign abs_z = in_accel_z[amsc_pkg::AXIS_W-1] ? (~in_accel_z + 1'b1) : in_accel_z;

  amsc_square u_sq_x (.clk(clk), .ctl(sq_ctl), .operand(abs_x), .product(sq_x));
  amsc_square u_sq_y (.clk(clk), .ctl(sq_ctl), .operand(abs_y), .product(sq_y));
  amsc_square u_sq_z (.clk(clk), .ctl(sq_ctl), .operand(abs_z), .product(sq_z));

  // three squares of at most 2^30 never carry out of 32 bits
  assign sum_sq = sq_x + sq_y + sq_z;

  amsc_isqrt u_isqrt (.clk(clk), .ctl(rt_ctl), .radicand(sum_sq), .root(mag));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      amsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_mode || frame_full) ? amsc_pkg::ST_FINISH : amsc_pkg::ST_SQUARE;
        end
      end
      amsc_pkg::ST_SQUARE: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = amsc_pkg::ST_SUM;
        end
      end
      amsc_pkg::ST_SUM: begin
        state_nxt = amsc_pkg::ST_ROOT;
      end
      amsc_pkg::ST_ROOT: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = amsc_pkg::ST_FINISH;
        end
      end
      amsc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = amsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = amsc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    sq_ctl      = '0;
    rt_ctl      = '0;
    finish_en   = 1'b0;
    unique case (state_r)
      amsc_pkg::ST_IDLE: begin
        in_ready    = rst_n;
        sq_ctl.load = in_valid;
      end
      amsc_pkg::ST_SQUARE: sq_ctl.step = 1'b1;
      amsc_pkg::ST_SUM:    rt_ctl.load = 1'b1;
      amsc_pkg::ST_ROOT:   rt_ctl.step = 1'b1;
      amsc_pkg::ST_FINISH: finish_en   = out_free;
      default: ;
    endcase
  end

  // peak tracking and step decision for a processed sample
  always_comb begin
    prev_mag_nxt = prev_mag_r;
    high_nxt     = high_r;
    low_nxt      = low_r;
    gap_nxt      = gap_r;
    steps_nxt    = steps_r;
    frame_nxt    = frame_r;
    stepped      = 1'b0;
    diff         = $signed({2'b00, mag}) - $signed({2'b00, prev_mag_r});
    thr_s        = $signed({2'b00, jump_thr_r});

    priority if (mode_r) begin
      // report request: hand back the count and clear it
      steps_nxt = '0;
    end else if (drop_r) begin
      // frame boundary: sample discarded, frame restarts
      frame_nxt = '0;
    end else begin
      if (prev_mag_r != '0) begin
        if (diff > thr_s) begin
          high_nxt = 1'b1;
          gap_nxt  = '0;
        end
        if (diff < -thr_s) begin
          low_nxt = 1'b1;
        end
        if (high_nxt && !low_nxt && (gap_nxt != amsc_pkg::GAP_TOP)) begin
          gap_nxt = gap_nxt + 1'b1;
        end
      end
      if (high_nxt && low_nxt && (gap_nxt < max_gap_r)) begin
        steps_nxt = steps_r + 1'b1;
        high_nxt  = 1'b0;
        low_nxt   = 1'b0;
        gap_nxt   = '0;
        stepped   = 1'b1;
      end
      prev_mag_nxt = mag;
      frame_nxt    = frame_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= amsc_pkg::ST_IDLE;
      cnt_r       <= '0;
      jump_thr_r  <= amsc_pkg::THR_RESET;
      max_gap_r   <= amsc_pkg::GAP_RESET;
      prev_mag_r  <= '0;
      high_r      <= 1'b0;
      low_r       <= 1'b0;
      gap_r       <= '0;
      steps_r     <= '0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      drop_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // shared step counter for the squaring and root phases
      if (state_r == amsc_pkg::ST_SQUARE || state_r == amsc_pkg::ST_ROOT) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          amsc_pkg::REG_JUMP_THRESHOLD: jump_thr_r <= cfg_data;
          amsc_pkg::REG_MAX_PEAK_GAP:   max_gap_r  <= cfg_data[amsc_pkg::GAP_W-1:0];
          default: ;
        endcase
      end

      // remember what kind of transaction is in flight
      if (in_valid && in_ready) begin
        mode_r <= in_mode;
        drop_r <= !in_mode && frame_full;
      end

      if (finish_en) begin
        prev_mag_r  <= prev_mag_nxt;
        high_r      <= high_nxt;
        low_r       <= low_nxt;
        gap_r       <= gap_nxt;
        steps_r     <= steps_nxt;
        frame_r     <= frame_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, report returns the count from before the clear
  always_ff @(posedge clk) begin
    if (finish_en) begin
      out_count_r <= mode_r ? steps_r : steps_nxt;
      out_taken_r <= stepped && !mode_r && !drop_r;
      out_used_r  <= !mode_r && !drop_r;
      out_mag_r   <= (mode_r || drop_r) ? '0 : mag;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_step_count  = out_count_r;
  assign out_step_taken  = out_taken_r;
  assign out_sample_used = out_used_r;
  assign out_magnitude   = out_mag_r;

endmodule

`default_nettype wire
